// ===== sv/ili_pkg.sv =====
package ili_pkg;

  localparam int unsigned ILI_DEPTH = 64;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;

  localparam int unsigned IN_BITS   = MODE_W + IDX_W + VAL_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = VAL_W + STAT_W + COUNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // broadcast to every cell of the row
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== sv/ili_cell.sv =====
module ili_cell #(
  parameter int unsigned POS = 0,
  parameter int unsigned PW  = 8
) (
  input  logic                         clk_i,
  input  ili_pkg::cell_ctrl_t          ctrl_i,
  input  logic [ili_pkg::VAL_W-1:0]    left_i,
  input  logic [ili_pkg::VAL_W-1:0]    right_i,
  output logic [ili_pkg::VAL_W-1:0]    value_o,
  output logic [ili_pkg::VAL_W-1:0]    rd_o
);
  import ili_pkg::*;

  localparam logic [PW-1:0] Pos = PW'(POS);

  logic [VAL_W-1:0] value_q, value_d;
  logic [PW-1:0]    idx_p;
  logic             at_idx;
  logic             above_idx;

  assign idx_p     = PW'(ctrl_i.idx);
  assign at_idx    = (Pos == idx_p);
  assign above_idx = (Pos > idx_p);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      // cells past the slot move up, the slot takes the new value
      if (above_idx) begin
        value_d = left_i;
      end else if (at_idx) begin
        value_d = ctrl_i.value;
      end
    end else if (ctrl_i.del) begin
      if (above_idx || at_idx) begin
        value_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign rd_o    = at_idx ? value_q : '0;

endmodule

// ===== sv/indexed_list_insert_delete.sv =====
// Position-addressed list of up to DEPTH signed 32-bit values held in a row
// of cells, cell 0 being the head. Each request reads, inserts before, or
// deletes at an index; insert and delete shift every later cell by one in
// the same cycle, so a request is answered in the cycle after it is taken and a
// new request is taken every cycle while the result register drains. Every
// result carries status (done, index out of range, list full) and the count
// after the operation; the count is reported in its low 7 bits.
module indexed_list_insert_delete #(
  parameter int unsigned DEPTH = ili_pkg::ILI_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // mode [1:0], index [8:2], value [40:9], zero fill above
  input  logic [ili_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // read_value [31:0], status [33:32], count [40:34], zero fill above
  output logic [ili_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);
  import ili_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned PW   = (CntW > IDX_W) ? CntW : IDX_W;

  logic [CntW-1:0]   entries_q, entries_d;
  logic              accept;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  idx;
  logic [VAL_W-1:0]  value;
  logic [PW-1:0]     idx_p, ent_p, ent_d_p;
  logic              full;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  rd_value;
  logic              do_ins, do_del;
  cell_ctrl_t        ctrl;

  logic [VAL_W-1:0]  cell_val [DEPTH];
  logic [VAL_W-1:0]  cell_rd  [DEPTH];

  logic                  m_valid_q;
  logic [OUT_BITS-1:0]   m_data_q;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;

  assign mode  = s_axis_tdata_i[MODE_W-1:0];
  assign idx   = s_axis_tdata_i[MODE_W+IDX_W-1:MODE_W];
  assign value = s_axis_tdata_i[IN_BITS-1:MODE_W+IDX_W];

  assign idx_p = PW'(idx);
  assign ent_p = PW'(entries_q);
  assign full  = (entries_q == CntW'(DEPTH));

  always_comb begin
    status = ST_DONE;
    do_ins = 1'b0;
    do_del = 1'b0;
    unique case (mode)
      MODE_READ: begin
        if (idx_p >= ent_p) begin
          status = ST_RANGE;
        end
      end
      MODE_INSERT: begin
        if (idx_p > ent_p) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      MODE_DELETE: begin
        if (idx_p >= ent_p) begin
          status = ST_RANGE;
        end else begin
          do_del = 1'b1;
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  always_comb begin
    entries_d = entries_q;
    if (accept && do_ins) begin
      entries_d = entries_q + CntW'(1);
    end else if (accept && do_del) begin
      entries_d = entries_q - CntW'(1);
    end
  end

  assign ent_d_p = PW'(entries_d);

  // only the addressed cell drives its read lane
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_value = rd_value | cell_rd[i];
    end
    if (mode != MODE_READ || status != ST_DONE) begin
      rd_value = '0;
    end
  end

  assign ctrl.ins   = accept && do_ins;
  assign ctrl.del   = accept && do_del;
  assign ctrl.idx   = idx;
  assign ctrl.value = value;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] left, right;
    if (g == 0) begin : g_head
      assign left = value;
    end else begin : g_body
      assign left = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right = cell_val[g];
    end else begin : g_inner
      assign right = cell_val[g+1];
    end
    ili_cell #(
      .POS (g),
      .PW  (PW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .value_o (cell_val[g]),
      .rd_o    (cell_rd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      entries_q <= entries_d;
      if (accept) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= {ent_d_p[COUNT_W-1:0], status, rd_value};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(m_data_q);

endmodule

// ===== tb/sv/indexed_list_insert_delete_tb.sv =====
`timescale 1ns / 1ps

module indexed_list_insert_delete_tb;
  import ili_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
  localparam int unsigned       RANDOM_ITEMS = 1125;
  localparam int unsigned       PHASE_LEN    = 130;
  localparam int unsigned       SETTLE_CYC   = 4;

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    bit                      sync;  // pause until all results are back
  } list_req_t;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic [STAT_W-1:0]       status;
    logic [COUNT_W-1:0]      count;
  } list_resp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  indexed_list_insert_delete uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  list_req_t   pending_reqs[$];
  list_resp_t  expected_resps[$];

  // shadow of the list contents as the block should hold them
  logic signed [VAL_W-1:0] shadow_cells[ILI_DEPTH];
  int unsigned             shadow_len = 0;
  int unsigned             gen_len = 0;

  logic        req_taken = 1'b0;
  int unsigned n_err = 0;
  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_range = 0;
  int unsigned n_refused = 0;
  int unsigned n_at_depth = 0;
  int unsigned n_emptied = 0;

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic void add_req(logic [MODE_W-1:0] mode, int unsigned idx,
                                  logic [VAL_W-1:0] val);
    list_req_t q;
    q.mode  = mode;
    q.index = idx[IDX_W-1:0];
    q.value = val;
    q.sync  = 1'b0;
    pending_reqs.push_back(q);
    // keep track of the length so random indices can stay mostly in range
    if (mode == MODE_INSERT && idx <= gen_len && gen_len < ILI_DEPTH)
      gen_len++;
    else if (mode == MODE_DELETE && idx < gen_len)
      gen_len--;
  endfunction

  function automatic void add_sync();
    list_req_t q;
    q.mode  = MODE_READ;
    q.index = '0;
    q.value = '0;
    q.sync  = 1'b1;
    pending_reqs.push_back(q);
  endfunction

  function automatic list_resp_t apply_list_op(logic [MODE_W-1:0] mode,
                                               logic [IDX_W-1:0] idx,
                                               logic signed [VAL_W-1:0] val);
    list_resp_t  r;
    int unsigned k;
    r.read_value = '0;
    r.status     = ST_DONE;
    case (mode)
      MODE_READ: begin
        if (idx < shadow_len) r.read_value = shadow_cells[idx];
        else r.status = ST_RANGE;
      end
      MODE_INSERT: begin
        if (idx > shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= ILI_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (k = shadow_len; k > idx; k--) shadow_cells[k] = shadow_cells[k-1];
          shadow_cells[idx] = val;
          shadow_len++;
        end
      end
      MODE_DELETE: begin
        if (idx >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (k = idx; k + 1 < shadow_len; k++) shadow_cells[k] = shadow_cells[k+1];
          shadow_len--;
        end
      end
      default: ;
    endcase
    r.count = shadow_len[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [VAL_W-1:0] want,
                                 logic [VAL_W-1:0] got);
    $display("%0t: mismatch in %s on result %0d: expected %0h, got %0h",
             $realtime, what, n_out, want, got);
    n_err++;
  endtask

  // request stream
  initial begin
    int unsigned phase, r, ins_p, del_p, idx;
    logic [MODE_W-1:0] mode;
    logic [VAL_W-1:0]  val;

    // empty list corners
    add_req(MODE_READ,   0, 32'h0000_0001);
    add_req(MODE_DELETE, 0, 32'h0000_0002);
    add_req(MODE_INSERT, 1, 32'h0000_0003);
    add_req(MODE_INSERT, 0, 32'h7FFF_FFFF);
    add_req(MODE_INSERT, 1, 32'h8000_0000);  // append at tail
    add_req(MODE_INSERT, 0, 32'hFFFF_FFFF);  // push at head
    add_req(MODE_INSERT, 1, 32'h0000_0000);
    add_req(MODE_READ,   0, 32'hFFFF_FFFF);
    add_req(MODE_READ,   1, 32'h0);
    add_req(MODE_READ,   2, 32'h0);
    add_req(MODE_READ,   3, 32'h0);
    add_req(MODE_READ,   4, 32'h0);
    add_req(MODE_READ,   127, 32'hFFFF_FFFF);
    add_req(MODE_UNUSED, 127, 32'hFFFF_FFFF);
    add_req(MODE_UNUSED, 0, 32'h0);
    add_req(MODE_INSERT, 127, 32'h1234_5678);
    add_req(MODE_INSERT, 5, 32'h1234_5678);
    add_req(MODE_DELETE, 127, 32'h0);
    add_req(MODE_DELETE, 4, 32'h0);
    add_req(MODE_DELETE, 1, 32'h0);
    add_req(MODE_DELETE, 2, 32'h0);           // last entry
    add_req(MODE_READ,   0, 32'h0);
    add_req(MODE_READ,   1, 32'h0);
    add_req(MODE_READ,   2, 32'h0);
    add_sync();

    // random phases: fill towards full, churn, then drain towards empty
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / PHASE_LEN) % 3;
      if (n % 300 == 299) add_sync();
      case (phase)
        0: begin ins_p = 70; del_p = 15; end
        2: begin ins_p = 15; del_p = 70; end
        default: begin ins_p = 35; del_p = 30; end
      endcase
      r = $urandom_range(0, 99);
      if (r < 2) mode = MODE_UNUSED;
      else if (r < 2 + ins_p) mode = MODE_INSERT;
      else if (r < 2 + ins_p + del_p) mode = MODE_DELETE;
      else mode = MODE_READ;

      if ($urandom_range(0, 99) < 12) idx = $urandom_range(0, 127);
      else if (mode == MODE_INSERT) idx = $urandom_range(0, gen_len);
      else if (gen_len == 0) idx = 0;
      else idx = $urandom_range(0, gen_len - 1);

      r = $urandom_range(0, 9);
      if (r == 0) begin
        case ($urandom_range(0, 3))
          0: val = 32'h0000_0000;
          1: val = 32'hFFFF_FFFF;
          2: val = 32'h8000_0000;
          default: val = 32'h7FFF_FFFF;
        endcase
      end else if (r == 1) begin
        val = $urandom_range(0, 15) - 8;
      end else begin
        val = $urandom;
      end
      add_req(mode, idx, val);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  always @(negedge clk_i) begin : drive_requests
    list_req_t          nxt;
    static int unsigned tx_gap = 0;
    static bit          calm_tx = 1'b0;
    if ($urandom_range(0, 199) == 0) calm_tx = !calm_tx;
    if (rst_ni && (!s_axis_tvalid_i || req_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_reqs.size() > 0 && pending_reqs[0].sync) begin
        s_axis_tvalid_i <= 1'b0;
        if (expected_resps.size() == 0) void'(pending_reqs.pop_front());
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {{(IN_DATA_W-IN_BITS){1'b0}}, nxt.value, nxt.index, nxt.mode};
        tx_gap = pick_gap(calm_tx);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure, with one long hold-off once the run is under way
  always @(negedge clk_i) begin : drive_ready
    static int unsigned rx_gap = 0;
    static int unsigned holdoff_left = 0;
    static bit          holdoff_used = 1'b0;
    static bit          calm_rx = 1'b0;
    if ($urandom_range(0, 199) == 0) calm_rx = !calm_rx;
    if (!holdoff_used && n_in >= 400) begin
      holdoff_used = 1'b1;
      holdoff_left = 150;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_axis_tready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      rx_gap = pick_gap(calm_rx);
    end
  end

  // monitor: check the result first, a request taken in the same cycle is newer
  always @(posedge clk_i) begin : watch_ports
    list_resp_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.read_value = m_axis_tdata_o[0 +: VAL_W];
        got.status     = m_axis_tdata_o[VAL_W +: STAT_W];
        got.count      = m_axis_tdata_o[VAL_W+STAT_W +: COUNT_W];
        if (expected_resps.size() == 0) begin
          report_mismatch("unexpected result", '0, m_axis_tdata_o[VAL_W-1:0]);
        end else begin
          want = expected_resps.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, got.read_value);
          if (got.status !== want.status)
            report_mismatch("status", VAL_W'(want.status), VAL_W'(got.status));
          if (got.count !== want.count)
            report_mismatch("count", VAL_W'(want.count), VAL_W'(got.count));
        end
        n_out++;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        want = apply_list_op(s_axis_tdata_i[MODE_W-1:0],
                             s_axis_tdata_i[MODE_W +: IDX_W],
                             s_axis_tdata_i[MODE_W+IDX_W +: VAL_W]);
        expected_resps.push_back(want);
        n_in++;
        if (want.status == ST_RANGE) n_range++;
        if (want.status == ST_FULL) n_refused++;
        if (want.count == ILI_DEPTH) n_at_depth++;
        if (s_axis_tdata_i[MODE_W-1:0] == MODE_DELETE && want.status == ST_DONE &&
            want.count == 0)
          n_emptied++;
      end
    end
    req_taken <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
  end

  initial begin
    @(posedge rst_ni);
    while (pending_reqs.size() != 0 || s_axis_tvalid_i || expected_resps.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (expected_resps.size() != 0)
      report_mismatch("results never returned", VAL_W'(expected_resps.size()), '0);
    $display("%0d requests sent, %0d results checked, %0d index range rejects",
             n_in, n_out, n_range);
    $display("list held %0d entries %0d times, %0d inserts refused when full, emptied %0d times",
             ILI_DEPTH, n_at_depth, n_refused, n_emptied);
    if (n_err == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout waiting for results");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
